[rtl/fpm_pkg.sv]
`default_nettype none
package fpm_pkg;

  localparam int unsigned NUM_ENTRIES = 12;
  localparam int unsigned NORM_STEPS  = 30;
  localparam int unsigned DIST_STEPS  = 34;
  localparam int unsigned ROOT_STAGES = 32;

  localparam logic [1:0] PLANE_LEFT   = 2'd0;
  localparam logic [1:0] PLANE_RIGHT  = 2'd1;
  localparam logic [1:0] PLANE_TOP    = 2'd2;
  localparam logic [1:0] PLANE_BOTTOM = 2'd3;

  typedef logic [NUM_ENTRIES-1:0][31:0] mat_t;

  typedef struct packed {
    logic [1:0]          id;
    logic signed [32:0]  a;
    logic signed [32:0]  b;
    logic signed [32:0]  c;
    logic signed [32:0]  d;
  } plane_t;

  // scaled magnitudes and everything the divide needs after the root
  typedef struct packed {
    logic [1:0]  id;
    logic        degen;
    logic        sa;
    logic        sb;
    logic        sc;
    logic        sd;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [30:0] mc;
    logic [32:0] md;
    logic [5:0]  lead;
  } side_t;

  typedef struct packed {
    logic [1:0]  id;
    logic [30:0] nx;
    logic [30:0] ny;
    logic [30:0] nz;
    logic [31:0] offs;
    logic        degen;
    logic        clip;
    logic        last;
  } res_t;

  // bring the largest magnitude into [2^30, 2^31)
  function automatic logic [30:0] scale_mag(logic [32:0] v, logic [5:0] lead);
    logic [32:0] t;
    if (lead > 6'd30) t = v >> (lead - 6'd30);
    else t = v << (6'd30 - lead);
    return t[30:0];
  endfunction

endpackage
`default_nettype wire

[rtl/fpm_front.sv]
`default_nettype none
module fpm_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            ce,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fpm_pkg::mat_t   in_mat,
  output logic                 pl_vld,
  output fpm_pkg::plane_t      pl
);

  fpm_pkg::mat_t   hold_r;
  logic            hold_vld_r;
  logic [1:0]      cnt_r;
  logic            pl_vld_r;
  fpm_pkg::plane_t pl_r;
  fpm_pkg::plane_t pl_nxt;
  logic            accept;

  assign in_ready = !hold_vld_r || (ce && cnt_r == fpm_pkg::PLANE_BOTTOM);
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic signed [32:0] r3v;
    logic signed [32:0] rxv;
    logic signed [3:0][32:0] coef;
    for (int j = 0; j < 4; j++) begin
      r3v = $signed({hold_r[8+j][31], hold_r[8+j]});
      if (cnt_r == fpm_pkg::PLANE_LEFT || cnt_r == fpm_pkg::PLANE_RIGHT)
        rxv = $signed({hold_r[j][31], hold_r[j]});
      else
        rxv = $signed({hold_r[4+j][31], hold_r[4+j]});
      if (cnt_r == fpm_pkg::PLANE_LEFT || cnt_r == fpm_pkg::PLANE_BOTTOM)
        coef[j] = r3v + rxv;
      else
        coef[j] = r3v - rxv;
    end
    pl_nxt.id = cnt_r;
    pl_nxt.a  = coef[0];
    pl_nxt.b  = coef[1];
    pl_nxt.c  = coef[2];
    pl_nxt.d  = coef[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      cnt_r      <= 2'd0;
      pl_vld_r   <= 1'b0;
    end else begin
      if (accept) hold_vld_r <= 1'b1;
      else if (ce && hold_vld_r && cnt_r == fpm_pkg::PLANE_BOTTOM) hold_vld_r <= 1'b0;
      if (ce) begin
        pl_vld_r <= hold_vld_r;
        if (hold_vld_r) cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hold_r <= in_mat;
    if (ce) pl_r <= pl_nxt;
  end

  assign pl_vld = pl_vld_r;
  assign pl     = pl_r;

endmodule
`default_nettype wire

[rtl/fpm_prep.sv]
`default_nettype none
module fpm_prep (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            ce,
  input  wire logic            pl_vld,
  input  wire fpm_pkg::plane_t pl,
  output logic                 sq_vld,
  output logic [63:0]          sq_sum,
  output fpm_pkg::side_t       sq_side
);

  // magnitudes and max
  logic        p1_vld_r;
  logic [1:0]  p1_id_r;
  logic [3:0]  p1_sgn_r;
  logic [32:0] p1_ma_r, p1_mb_r, p1_mc_r, p1_md_r, p1_m_r;
  // leading one
  logic        p2_vld_r;
  logic [1:0]  p2_id_r;
  logic [3:0]  p2_sgn_r;
  logic [32:0] p2_ma_r, p2_mb_r, p2_mc_r, p2_md_r;
  logic        p2_degen_r;
  logic [5:0]  p2_lead_r;
  logic [5:0]  lead_nxt;
  // scaled, squared, summed
  logic           p3_vld_r, p4_vld_r, p5_vld_r;
  fpm_pkg::side_t p3_side_r, p4_side_r, p5_side_r;
  fpm_pkg::side_t side_nxt;
  logic [61:0]    sqa_r, sqb_r, sqc_r;
  logic [63:0]    sum_r;
  logic [32:0]    ma_nxt, mb_nxt, mc_nxt, md_nxt, m_nxt;

  always_comb begin
    ma_nxt = pl.a[32] ? 33'(-pl.a) : 33'(pl.a);
    mb_nxt = pl.b[32] ? 33'(-pl.b) : 33'(pl.b);
    mc_nxt = pl.c[32] ? 33'(-pl.c) : 33'(pl.c);
    md_nxt = pl.d[32] ? 33'(-pl.d) : 33'(pl.d);
    m_nxt  = ma_nxt;
    if (mb_nxt > m_nxt) m_nxt = mb_nxt;
    if (mc_nxt > m_nxt) m_nxt = mc_nxt;
  end

  always_comb begin
    lead_nxt = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (p1_m_r[i]) lead_nxt = 6'(i);
    end
  end

  always_comb begin
    side_nxt.id    = p2_id_r;
    side_nxt.degen = p2_degen_r;
    side_nxt.sa    = p2_sgn_r[0];
    side_nxt.sb    = p2_sgn_r[1];
    side_nxt.sc    = p2_sgn_r[2];
    side_nxt.sd    = p2_sgn_r[3];
    side_nxt.ma    = fpm_pkg::scale_mag(p2_ma_r, p2_lead_r);
    side_nxt.mb    = fpm_pkg::scale_mag(p2_mb_r, p2_lead_r);
    side_nxt.mc    = fpm_pkg::scale_mag(p2_mc_r, p2_lead_r);
    side_nxt.md    = p2_md_r;
    side_nxt.lead  = p2_lead_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
      p4_vld_r <= 1'b0;
      p5_vld_r <= 1'b0;
    end else if (ce) begin
      p1_vld_r <= pl_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_id_r    <= pl.id;
      p1_sgn_r   <= {pl.d[32], pl.c[32], pl.b[32], pl.a[32]};
      p1_ma_r    <= ma_nxt;
      p1_mb_r    <= mb_nxt;
      p1_mc_r    <= mc_nxt;
      p1_md_r    <= md_nxt;
      p1_m_r     <= m_nxt;
      p2_id_r    <= p1_id_r;
      p2_sgn_r   <= p1_sgn_r;
      p2_ma_r    <= p1_ma_r;
      p2_mb_r    <= p1_mb_r;
      p2_mc_r    <= p1_mc_r;
      p2_md_r    <= p1_md_r;
      p2_degen_r <= (p1_m_r == 33'd0);
      p2_lead_r  <= lead_nxt;
      p3_side_r  <= side_nxt;
      sqa_r      <= 62'(p3_side_r.ma) * 62'(p3_side_r.ma);
      sqb_r      <= 62'(p3_side_r.mb) * 62'(p3_side_r.mb);
      sqc_r      <= 62'(p3_side_r.mc) * 62'(p3_side_r.mc);
      p4_side_r  <= p3_side_r;
      sum_r      <= 64'(sqa_r) + 64'(sqb_r) + 64'(sqc_r);
      p5_side_r  <= p4_side_r;
    end
  end

  assign sq_vld  = p5_vld_r;
  assign sq_sum  = sum_r;
  assign sq_side = p5_side_r;

endmodule
`default_nettype wire

[rtl/fpm_sqrt.sv]
`default_nettype none
module fpm_sqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ce,
  input  wire logic           sq_vld,
  input  wire logic [63:0]    sq_sum,
  input  wire fpm_pkg::side_t sq_side,
  output logic                rt_vld,
  output logic [31:0]         rt_root,
  output fpm_pkg::side_t      rt_side
);

  localparam int unsigned N = fpm_pkg::ROOT_STAGES;

  logic [N-1:0]          vld_r;
  logic [N-1:0][63:0]    s_r;
  logic [N-1:0][33:0]    rem_r;
  logic [N-1:0][31:0]    root_r;
  fpm_pkg::side_t        side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [63:0]    s_in;
    logic [33:0]    rem_in;
    logic [31:0]    root_in;
    logic           vld_in;
    fpm_pkg::side_t side_in;
    logic [35:0]    t;
    logic [35:0]    trial;

    if (i == 0) begin : g_first
      assign s_in    = sq_sum;
      assign rem_in  = 34'd0;
      assign root_in = 32'd0;
      assign vld_in  = sq_vld;
      assign side_in = sq_side;
    end else begin : g_next
      assign s_in    = s_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign vld_in  = vld_r[i-1];
      assign side_in = side_r[i-1];
    end

    // one result bit per stage, two radicand bits brought down
    assign t     = {rem_in, s_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else if (ce) vld_r[i] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        s_r[i]    <= {s_in[61:0], 2'b00};
        side_r[i] <= side_in;
        if (t >= trial) begin
          rem_r[i]  <= 34'(t - trial);
          root_r[i] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[i]  <= t[33:0];
          root_r[i] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign rt_vld  = vld_r[N-1];
  assign rt_root = root_r[N-1];
  assign rt_side = side_r[N-1];

endmodule
`default_nettype wire

[rtl/fpm_div.sv]
`default_nettype none
module fpm_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ce,
  input  wire logic           rt_vld,
  input  wire logic [31:0]    rt_root,
  input  wire fpm_pkg::side_t rt_side,
  output logic                res_vld,
  output fpm_pkg::res_t       res
);

  localparam int unsigned NS = fpm_pkg::NORM_STEPS;
  localparam int unsigned DS = fpm_pkg::DIST_STEPS;

  typedef struct packed {
    logic [31:0]          len;
    logic [2:0][31:0]     nrem;
    logic [2:0][NS-1:0]   nlow;
    logic [2:0][NS-1:0]   nq;
    logic [31:0]          drem;
    logic [DS-1:0]        dlow;
    logic [DS-1:0]        dq;
    logic                 sat;
  } dstage_t;

  dstage_t        st_r   [DS+1];
  fpm_pkg::side_t side_r [DS+1];
  logic [DS:0]    vld_r;

  dstage_t       st0_nxt;
  logic [60:0]   num0, num1, num2;
  logic [78:0]   dnum;

  // numerators are component*2^29 + len/2 and |d| shifted left by 46-lead
  always_comb begin
    num0 = 61'({rt_side.ma, 29'd0}) + 61'(rt_root[31:1]);
    num1 = 61'({rt_side.mb, 29'd0}) + 61'(rt_root[31:1]);
    num2 = 61'({rt_side.mc, 29'd0}) + 61'(rt_root[31:1]);
    dnum = 79'(rt_side.md) << (6'd46 - rt_side.lead);
    st0_nxt.len     = rt_root;
    st0_nxt.nrem[0] = 32'(num0[60:NS]);
    st0_nxt.nrem[1] = 32'(num1[60:NS]);
    st0_nxt.nrem[2] = 32'(num2[60:NS]);
    st0_nxt.nlow[0] = num0[NS-1:0];
    st0_nxt.nlow[1] = num1[NS-1:0];
    st0_nxt.nlow[2] = num2[NS-1:0];
    st0_nxt.nq      = '0;
    st0_nxt.drem    = dnum[DS+31:DS];
    st0_nxt.dlow    = dnum[DS-1:0];
    st0_nxt.dq      = '0;
    st0_nxt.sat     = (dnum[78:DS] >= 45'(rt_root));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (ce) vld_r[0] <= rt_vld;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      st_r[0]   <= st0_nxt;
      side_r[0] <= rt_side;
    end
  end

  for (genvar j = 1; j <= DS; j++) begin : g_step
    dstage_t nxt;

    always_comb begin
      logic [32:0] t;
      nxt = st_r[j-1];
      if (j <= NS) begin
        for (int l = 0; l < 3; l++) begin
          t = {st_r[j-1].nrem[l], st_r[j-1].nlow[l][NS-1]};
          nxt.nlow[l] = {st_r[j-1].nlow[l][NS-2:0], 1'b0};
          if (t >= {1'b0, st_r[j-1].len}) begin
            nxt.nrem[l] = 32'(t - {1'b0, st_r[j-1].len});
            nxt.nq[l]   = {st_r[j-1].nq[l][NS-2:0], 1'b1};
          end else begin
            nxt.nrem[l] = t[31:0];
            nxt.nq[l]   = {st_r[j-1].nq[l][NS-2:0], 1'b0};
          end
        end
      end
      t = {st_r[j-1].drem, st_r[j-1].dlow[DS-1]};
      nxt.dlow = {st_r[j-1].dlow[DS-2:0], 1'b0};
      if (t >= {1'b0, st_r[j-1].len}) begin
        nxt.drem = 32'(t - {1'b0, st_r[j-1].len});
        nxt.dq   = {st_r[j-1].dq[DS-2:0], 1'b1};
      end else begin
        nxt.drem = t[31:0];
        nxt.dq   = {st_r[j-1].dq[DS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j] <= 1'b0;
      else if (ce) vld_r[j] <= vld_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        st_r[j]   <= nxt;
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // rounding, saturation, signs and zeroing of degenerate planes
  dstage_t        fin;
  fpm_pkg::side_t fsd;
  fpm_pkg::res_t  res_nxt;
  logic           res_vld_r;
  fpm_pkg::res_t  res_r;

  assign fin = st_r[DS];
  assign fsd = side_r[DS];

  always_comb begin
    logic [34:0] qd;
    logic [34:0] lim;
    logic [34:0] mag;
    logic        clip;
    qd   = 35'(fin.dq) + 35'({fin.drem, 1'b0} >= {1'b0, fin.len});
    lim  = fsd.sd ? 35'h080000000 : 35'h07fffffff;
    clip = fin.sat || (qd > lim);
    mag  = clip ? lim : qd;
    res_nxt.id    = fsd.id;
    res_nxt.last  = (fsd.id == fpm_pkg::PLANE_BOTTOM);
    res_nxt.nx    = fsd.sa ? 31'(-{1'b0, fin.nq[0]}) : {1'b0, fin.nq[0]};
    res_nxt.ny    = fsd.sb ? 31'(-{1'b0, fin.nq[1]}) : {1'b0, fin.nq[1]};
    res_nxt.nz    = fsd.sc ? 31'(-{1'b0, fin.nq[2]}) : {1'b0, fin.nq[2]};
    res_nxt.offs  = fsd.sd ? 32'(-mag[31:0]) : mag[31:0];
    res_nxt.degen = 1'b0;
    res_nxt.clip  = clip;
    if (fsd.degen) begin
      res_nxt.nx    = '0;
      res_nxt.ny    = '0;
      res_nxt.nz    = '0;
      res_nxt.offs  = '0;
      res_nxt.degen = 1'b1;
      res_nxt.clip  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else if (ce) res_vld_r <= vld_r[DS];
  end

  always_ff @(posedge clk) begin
    if (ce) res_r <= res_nxt;
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule
`default_nettype wire

[rtl/frustum_planes_from_clip_matrix.sv]
`default_nettype none
// Frustum side planes from a clip matrix. One input item carries rows 0, 1
// and 3 of the matrix (twelve Q16.16 words); it yields four result items in
// the order left, right, top, bottom, each a unit normal in Q2.29 and a
// Q16.16 distance, with flags for a zero normal and a saturated distance.
// A new matrix is taken only as the bottom plane of the last one is issued;
// the four planes leave one per cycle, while the output is not stalled,
// from a single shared pipeline: the plane sequencer feeds that pipeline
// one plane a cycle. Each plane passes the matrix hold and plane registers,
// 5 setup stages, 32 square-root stages, 35 divide stages and the output
// register. The whole pipeline holds still while the output is stalled.
module frustum_planes_from_clip_matrix (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // r0_c0, r0_c1, r0_c2, r0_c3, r1_c0 .. r1_c3, r3_c0 .. r3_c3, 32 bits each
  input  wire logic [383:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // norm_x, norm_y, norm_z, dist_res, degenerate, clipped, one zero pad bit
  output logic [127:0]      out_tdata,
  // plane_id
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic            ce;
  logic            pl_vld;
  fpm_pkg::plane_t pl;
  logic            sq_vld;
  logic [63:0]     sq_sum;
  fpm_pkg::side_t  sq_side;
  logic            rt_vld;
  logic [31:0]     rt_root;
  fpm_pkg::side_t  rt_side;
  logic            res_vld;
  fpm_pkg::res_t   res;

  assign ce = !res_vld || out_tready;

  fpm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mat   (fpm_pkg::mat_t'(in_tdata)),
    .pl_vld   (pl_vld),
    .pl       (pl)
  );

  fpm_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .pl_vld  (pl_vld),
    .pl      (pl),
    .sq_vld  (sq_vld),
    .sq_sum  (sq_sum),
    .sq_side (sq_side)
  );

  fpm_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .sq_vld  (sq_vld),
    .sq_sum  (sq_sum),
    .sq_side (sq_side),
    .rt_vld  (rt_vld),
    .rt_root (rt_root),
    .rt_side (rt_side)
  );

  fpm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .rt_vld  (rt_vld),
    .rt_root (rt_root),
    .rt_side (rt_side),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {1'b0, res.clip, res.degen, res.offs, res.nz, res.ny, res.nx};
  assign out_tuser  = res.id;
  assign out_tlast  = res.last;

  // a matrix occupies the sequencer for four planes
  a_hold_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while planes still pending");

  a_last_bottom : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == fpm_pkg::PLANE_BOTTOM)))
    else $error("last flag not on the bottom plane");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[125] |-> !out_tdata[126] && out_tdata[124:0] == 125'd0)
    else $error("degenerate plane with nonzero fields");

  a_plane_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      !out_tvalid || out_tuser == $past(out_tuser) + 2'd1)
    else $error("planes out of order");

endmodule
`default_nettype wire
